// ===== hdl/ablm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the block level meter.
// No dependencies; every other file of the block imports this package.
package ablm_pkg;

    localparam int BLOCK_MAX_DEF = 256;
    localparam int SAMPLE_W      = 16;
    localparam int MAG_W         = 16;
    localparam int SMOOTH_W      = 24;
    localparam int FRAC_W        = 8;
    localparam int WEIGHT_W      = 9;
    localparam int LENGTH_W      = 9;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 9'd256;
    localparam logic [WEIGHT_W-1:0] RMS_KEEP_RESET  = 9'd192;
    localparam logic [WEIGHT_W-1:0] PEAK_KEEP_RESET = 9'd166;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX      = 24'h800000;
    localparam logic [MAG_W-1:0]    MAG_MAX         = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_RMS_KEEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_KEEP = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_block;
    } ablm_in_t;

    typedef struct packed {
        logic [SMOOTH_W-1:0] smoothed_rms;
        logic [SMOOTH_W-1:0] smoothed_peak;
        logic [MAG_W-1:0]    block_rms;
        logic [MAG_W-1:0]    block_peak;
        logic [LENGTH_W-1:0] block_length;
    } ablm_out_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ablm_q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ROOT,
        BK_MUL,
        BK_ADD,
        BK_OUT
    } ablm_back_state_t;

    // Keep weights above one saturate to one.
    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
        return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

endpackage

// ===== hdl/audio_block_level_meter_core.sv =====
`timescale 1ns / 1ps
// Top level of the block level meter: config registers, front, queue, back.
// Uses ablm_pkg, ablm_front, ablm_queue and ablm_back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   samples  | sample_valid/sample_ready  | sample_data  (ablm_in_t)
//   results  | result_valid/result_ready  | result_data  (ablm_out_t)
//   config   | cfg_valid/cfg_ready        | cfg_index, cfg_data (keep weight)
//
// The front takes one sample per cycle while the two-entry block queue has room.
// The back runs each closed block through a bit-serial divider and square root.
// Short blocks can stall the sample channel once the queue is full.
// A stalled result register holds the back in its output step.
// Reset is asynchronous: weights return to 192 and 166, stores and sums to zero.
module audio_block_level_meter_core #(
    parameter int BLOCK_MAX = ablm_pkg::BLOCK_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  ablm_pkg::ablm_in_t                sample_data,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ablm_pkg::ablm_out_t               result_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ablm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ablm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ablm_pkg::*;

    localparam int CNT_W   = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W   = 2 * MAG_W - 1 + $clog2(BLOCK_MAX);
    localparam int ENTRY_W = SUM_W + CNT_W + MAG_W;

    logic [WEIGHT_W-1:0] rms_keep_reg;
    logic [WEIGHT_W-1:0] rms_keep_next;
    logic [WEIGHT_W-1:0] peak_keep_reg;
    logic [WEIGHT_W-1:0] peak_keep_next;
    ablm_q_status_t      q_status;
    logic                push;
    logic [ENTRY_W-1:0]  push_data;
    logic                pop;
    logic [ENTRY_W-1:0]  pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rms_keep_next  = rms_keep_reg;
        peak_keep_next = peak_keep_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RMS_KEEP:  rms_keep_next  = WEIGHT_W'(cfg_data);
                CFG_PEAK_KEEP: peak_keep_next = WEIGHT_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rms_keep_reg  <= RMS_KEEP_RESET;
            peak_keep_reg <= PEAK_KEEP_RESET;
        end
        else
        begin
            rms_keep_reg  <= rms_keep_next;
            peak_keep_reg <= peak_keep_next;
        end
    end

    ablm_front #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    ablm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    ablm_back #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (pop_data),
        .pop          (pop),
        .rms_keep     (rms_keep_reg),
        .peak_keep    (peak_keep_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

// ===== hdl/ablm_front.sv =====
`timescale 1ns / 1ps
// Front part: takes samples, accumulates squares, count and peak per block.
// Uses ablm_pkg; pushes one closed-block record into the queue per block.
module ablm_front #(
    parameter int  BLOCK_MAX = ablm_pkg::BLOCK_MAX_DEF,
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1),
    localparam int SUM_W     = 2 * ablm_pkg::MAG_W - 1 + $clog2(BLOCK_MAX),
    localparam int ENTRY_W   = SUM_W + CNT_W + ablm_pkg::MAG_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  ablm_pkg::ablm_in_t      sample_data,
    input  ablm_pkg::ablm_q_status_t q_status,
    output logic                    push,
    output logic [ENTRY_W-1:0]      push_data
);
    import ablm_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [MAG_W-1:0]   peak_reg;
    logic [MAG_W-1:0]   peak_next;
    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] square;
    logic [SUM_W-1:0]   sum_inc;
    logic [CNT_W-1:0]   count_inc;
    logic [MAG_W-1:0]   peak_inc;
    logic               accept;
    logic               close;

    // -32768 maps to 0x8000, which is its magnitude read as unsigned
    assign mag = sample_data.sample[SAMPLE_W-1] ? MAG_W'(unsigned'(-sample_data.sample))
                                                : MAG_W'(unsigned'(sample_data.sample));
    assign square    = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
    assign sum_inc   = sum_reg + SUM_W'(square);
    assign count_inc = count_reg + CNT_W'(1);
    assign peak_inc  = (mag > peak_reg) ? mag : peak_reg;
    assign close     = sample_data.last_in_block || (count_inc == CNT_W'(BLOCK_MAX));

    assign sample_ready = !q_status.full;
    assign accept       = sample_valid && sample_ready;
    assign push         = accept && close;
    assign push_data    = {sum_inc, count_inc, peak_inc};

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        peak_next  = peak_reg;
        if (accept)
        begin
            if (close)
            begin
                sum_next   = '0;
                count_next = '0;
                peak_next  = '0;
            end
            else
            begin
                sum_next   = sum_inc;
                count_next = count_inc;
                peak_next  = peak_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
        end
    end

endmodule

// ===== hdl/ablm_queue.sv =====
`timescale 1ns / 1ps
// Short register queue between the front and back parts.
// Uses ablm_pkg for the status struct.
module ablm_queue #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = ablm_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    input  logic                     pop,
    output logic [WIDTH-1:0]         pop_data,
    output ablm_pkg::ablm_q_status_t status
);
    import ablm_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/ablm_back.sv =====
`timescale 1ns / 1ps
// Back part: per closed block, divide sum by count, integer square root,
// exponential smoothing, then the result register. Uses ablm_pkg.
module ablm_back #(
    parameter int  BLOCK_MAX = ablm_pkg::BLOCK_MAX_DEF,
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1),
    localparam int SUM_W     = 2 * ablm_pkg::MAG_W - 1 + $clog2(BLOCK_MAX),
    localparam int ENTRY_W   = SUM_W + CNT_W + ablm_pkg::MAG_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ablm_pkg::ablm_q_status_t           q_status,
    input  logic [ENTRY_W-1:0]                 q_data,
    output logic                               pop,
    input  logic [ablm_pkg::WEIGHT_W-1:0]      rms_keep,
    input  logic [ablm_pkg::WEIGHT_W-1:0]      peak_keep,
    output logic                               result_valid,
    input  logic                               result_ready,
    output ablm_pkg::ablm_out_t                result_data
);
    import ablm_pkg::*;

    localparam int SQ_STEPS = (SUM_W + 1) / 2;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int PROD_W   = SMOOTH_W + WEIGHT_W;
    localparam logic [SUM_W-1:0] SQ_TOP = SUM_W'(1) << (2 * (SQ_STEPS - 1));

    ablm_back_state_t state_reg;
    ablm_back_state_t state_next;

    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    quo_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [MAG_W-1:0]    peak_reg;
    logic [MAG_W-1:0]    peak_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [SUM_W-1:0]    res_reg;
    logic [SUM_W-1:0]    res_next;
    logic [SUM_W-1:0]    bit_reg;
    logic [SUM_W-1:0]    bit_next;
    logic [PROD_W-1:0]   rms_old_reg;
    logic [PROD_W-1:0]   rms_new_reg;
    logic [PROD_W-1:0]   peak_old_reg;
    logic [PROD_W-1:0]   peak_new_reg;
    logic [SMOOTH_W-1:0] rms_store_reg;
    logic [SMOOTH_W-1:0] rms_store_next;
    logic [SMOOTH_W-1:0] peak_store_reg;
    logic [SMOOTH_W-1:0] peak_store_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    ablm_out_t           result_data_reg;
    ablm_out_t           result_data_next;

    logic [SUM_W-1:0]    e_sum;
    logic [CNT_W-1:0]    e_count;
    logic [MAG_W-1:0]    e_peak;
    logic [CNT_W:0]      div_shift;
    logic                div_ge;
    logic [CNT_W:0]      div_diff;
    logic [SUM_W-1:0]    div_quo;
    logic [SUM_W:0]      root_sum;
    logic                root_ge;
    logic [WEIGHT_W-1:0] k_rms;
    logic [WEIGHT_W-1:0] k_peak;
    logic [MAG_W-1:0]    blk_rms;
    logic [PROD_W:0]     rms_acc;
    logic [PROD_W:0]     peak_acc;
    logic                out_free;

    assign e_sum   = q_data[ENTRY_W-1 -: SUM_W];
    assign e_count = q_data[MAG_W +: CNT_W];
    assign e_peak  = q_data[MAG_W-1:0];

    // Restoring division, one quotient bit per cycle, MSB first
    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, count_reg});
    assign div_diff  = div_shift - {1'b0, count_reg};
    assign div_quo   = {quo_reg[SUM_W-2:0], div_ge};

    // Digit-by-digit root, quo_reg holds the shrinking radicand
    assign root_sum = {1'b0, res_reg} + {1'b0, bit_reg};
    assign root_ge  = ({1'b0, quo_reg} >= root_sum);

    assign blk_rms  = res_reg[MAG_W-1:0];
    assign k_rms    = sat_weight(rms_keep);
    assign k_peak   = sat_weight(peak_keep);
    assign rms_acc  = {1'b0, rms_old_reg} + {1'b0, rms_new_reg};
    assign peak_acc = {1'b0, peak_old_reg} + {1'b0, peak_new_reg};
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_ADD;
            end
            BK_ADD:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop               = 1'b0;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        count_next        = count_reg;
        peak_next         = peak_reg;
        step_next         = step_reg;
        res_next          = res_reg;
        bit_next          = bit_reg;
        rms_store_next    = rms_store_reg;
        peak_store_next   = peak_store_reg;
        result_data_next  = result_data_reg;
        result_valid_next = result_valid_reg && !result_ready;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    quo_next   = e_sum;
                    rem_next   = '0;
                    count_next = e_count;
                    peak_next  = e_peak;
                    step_next  = STEP_W'(SUM_W - 1);
                end
            end
            BK_DIV:
            begin
                quo_next  = div_quo;
                rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                step_next = step_reg - STEP_W'(1);
                res_next  = '0;
                bit_next  = SQ_TOP;
            end
            BK_ROOT:
            begin
                if (root_ge)
                begin
                    quo_next = quo_reg - root_sum[SUM_W-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            BK_ADD:
            begin
                rms_store_next  = rms_acc[SMOOTH_W+FRAC_W-1:FRAC_W];
                peak_store_next = peak_acc[SMOOTH_W+FRAC_W-1:FRAC_W];
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next              = 1'b1;
                    result_data_next.smoothed_rms  = rms_store_reg;
                    result_data_next.smoothed_peak = peak_store_reg;
                    result_data_next.block_rms     = blk_rms;
                    result_data_next.block_peak    = peak_reg;
                    result_data_next.block_length  = LENGTH_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            rms_store_reg    <= '0;
            peak_store_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rms_store_reg    <= rms_store_next;
            peak_store_reg   <= peak_store_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        count_reg       <= count_next;
        peak_reg        <= peak_next;
        step_reg        <= step_next;
        res_reg         <= res_next;
        bit_reg         <= bit_next;
        result_data_reg <= result_data_next;
        rms_old_reg     <= PROD_W'(rms_store_reg) * PROD_W'(k_rms);
        rms_new_reg     <= PROD_W'({blk_rms, {FRAC_W{1'b0}}}) * PROD_W'(WEIGHT_ONE - k_rms);
        peak_old_reg    <= PROD_W'(peak_store_reg) * PROD_W'(k_peak);
        peak_new_reg    <= PROD_W'({peak_reg, {FRAC_W{1'b0}}}) * PROD_W'(WEIGHT_ONE - k_peak);
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

// ===== hdl/ablm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the block level meter.
// Uses ablm_pkg; bound to audio_block_level_meter_core at the end of this file.
module ablm_checker #(
    parameter int BLOCK_MAX = ablm_pkg::BLOCK_MAX_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input ablm_pkg::ablm_out_t result_data
);
    import ablm_pkg::*;

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.block_rms <= result_data.block_peak)
        else $error("block rms above block peak");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.block_peak <= MAG_MAX
                      && result_data.smoothed_rms <= SMOOTH_MAX
                      && result_data.smoothed_peak <= SMOOTH_MAX)
        else $error("result value out of range");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (BLOCK_MAX >= 512)
                      || (result_data.block_length != '0
                          && int'(result_data.block_length) <= BLOCK_MAX))
        else $error("block length out of range");

endmodule

bind audio_block_level_meter_core ablm_checker #(
    .BLOCK_MAX (BLOCK_MAX)
) u_ablm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// ===== bench/tb_audio_block_level_meter_core.sv =====
`timescale 1ns / 1ps
// Testbench for audio_block_level_meter_core. It drives sample blocks and keep-weight
// writes, predicts each block result on its own, and checks each field in order.
// Depends on ablm_pkg and the RTL under hdl/.
module tb_audio_block_level_meter_core;
    import ablm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;
    localparam int RANDOM_SAMPLES   = 900;
    localparam int FULL_RATE_ITEMS  = 150;
    localparam int CFG_SPACING      = 250;
    localparam int SETTLE_CYCLES    = 80;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int IDLE_PERCENT     = 19;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    ablm_in_t              sample_data  = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    ablm_out_t             result_data;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    bit idle_on         = 1'b1;
    int mismatches      = 0;
    int samples_sent    = 0;
    int blocks_checked  = 0;
    int weight_settings = 0;

    // Meter state as the bench sees it
    logic [WEIGHT_W-1:0] rms_keep   = RMS_KEEP_RESET;
    logic [WEIGHT_W-1:0] peak_keep  = PEAK_KEEP_RESET;
    longint unsigned     energy_sum = 0;
    int unsigned         peak_run   = 0;
    int unsigned         run_length = 0;
    int unsigned         rms_level  = 0;
    int unsigned         peak_level = 0;
    ablm_out_t           level_q[$];

    always #5 clk = ~clk;

    audio_block_level_meter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic int unsigned floor_root(longint unsigned v);
        int unsigned     r;
        longint unsigned trial;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = 64'(r | (32'd1 << b));
            if (trial * trial <= v)
                r = 32'(trial);
        end
        return r;
    endfunction

    function automatic int unsigned ema_step(int unsigned old_v, logic [WEIGHT_W-1:0] w,
                                             int unsigned x);
        longint unsigned k;
        longint unsigned o;
        longint unsigned n;
        longint unsigned acc;
        k = (w > WEIGHT_ONE) ? 64'd256 : 64'(w);
        o = 64'(old_v);
        n = 64'(x);
        acc = o * k + (n << 8) * (64'd256 - k);
        return 32'((acc >> 8) & 64'hFFFFFF);
    endfunction

    // Fold one accepted sample into the block; queue a result when the block closes.
    function automatic void absorb_sample(ablm_in_t item);
        int          s;
        int unsigned mag;
        int unsigned root;
        ablm_out_t   want;
        s = int'(item.sample);
        mag = (s < 0) ? -s : s;
        energy_sum += 64'(mag) * 64'(mag);
        if (mag > peak_run)
            peak_run = mag;
        run_length++;
        if (!item.last_in_block && run_length < BLOCK_MAX_DEF)
            return;
        root = floor_root(energy_sum / 64'(run_length));
        rms_level = ema_step(rms_level, rms_keep, root);
        peak_level = ema_step(peak_level, peak_keep, peak_run);
        want.smoothed_rms = SMOOTH_W'(rms_level);
        want.smoothed_peak = SMOOTH_W'(peak_level);
        want.block_rms = MAG_W'(root);
        want.block_peak = MAG_W'(peak_run);
        want.block_length = LENGTH_W'(run_length);
        level_q.push_back(want);
        energy_sum = 0;
        peak_run = 0;
        run_length = 0;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want_v,
                                          logic [31:0] got_v);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want_v, got_v);
    endfunction

    function automatic void check_field(string what, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (want_v !== got_v)
            note_mismatch(what, want_v, got_v);
    endfunction

    always @(posedge clk)
        result_ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;

    always @(posedge clk)
    begin : check_results
        ablm_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (level_q.size() == 0)
                note_mismatch("unexpected result, block_length", 0,
                              32'(result_data.block_length));
            else
            begin
                want = level_q.pop_front();
                check_field("smoothed_rms", 32'(want.smoothed_rms),
                            32'(result_data.smoothed_rms));
                check_field("smoothed_peak", 32'(want.smoothed_peak),
                            32'(result_data.smoothed_peak));
                check_field("block_rms", 32'(want.block_rms), 32'(result_data.block_rms));
                check_field("block_peak", 32'(want.block_peak), 32'(result_data.block_peak));
                check_field("block_length", 32'(want.block_length),
                            32'(result_data.block_length));
                blocks_checked++;
            end
        end
    end

    // Hold valid high across back-to-back transactions; drop it only while idling.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
        ablm_in_t item;
        item.sample = s;
        item.last_in_block = last;
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_valid <= 1'b1;
        sample_data <= item;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        absorb_sample(item);
        samples_sent++;
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_RMS_KEEP)
            rms_keep = WEIGHT_W'(val);
        else if (idx == CFG_PEAK_KEEP)
            peak_keep = WEIGHT_W'(val);
    endtask

    // Writes to unmapped indexes ride along and must change nothing.
    task automatic configure(input logic [WEIGHT_W-1:0] rms_w,
                             input logic [WEIGHT_W-1:0] peak_w);
        drain();
        write_reg(($urandom_range(1) != 0) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                  CFG_DATA_W'($urandom));
        write_reg(CFG_RMS_KEEP, CFG_DATA_W'(rms_w));
        write_reg(CFG_PEAK_KEEP, CFG_DATA_W'(peak_w));
        cfg_valid <= 1'b0;
        weight_settings++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return SAMPLE_W'($urandom_range(16) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(4))
            0: return 9'd0;
            1: return WEIGHT_ONE;
            2: return WEIGHT_W'($urandom_range(511, 257));
            default: return WEIGHT_W'($urandom_range(256));
        endcase
    endfunction

    // Mostly short blocks; now and then a long one or one that closes at full length.
    task automatic send_random_block();
        int len;
        int pick;
        pick = $urandom_range(39);
        if (pick == 0)
            len = BLOCK_MAX_DEF;
        else if (pick < 5)
            len = $urandom_range(BLOCK_MAX_DEF - 1, 17);
        else
            len = $urandom_range(16, 1);
        for (int i = 1; i <= len; i++)
            send_sample(pick_sample(),
                        (i == len) && (len < BLOCK_MAX_DEF || $urandom_range(1) != 0));
    endtask

    task automatic test_reset_weights();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd3, 1'b1);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);
        drain();
    endtask

    // Full-scale block with no end flag: it must close on length alone.
    task automatic test_block_max();
        repeat (BLOCK_MAX_DEF) send_sample(16'sh8000, 1'b0);
        send_sample(16'sd100, 1'b1);
        drain();
    endtask

    task automatic test_weight_extremes();
        configure(9'd0, 9'd0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd2, 1'b1);
        configure(WEIGHT_ONE, WEIGHT_ONE);
        send_sample(16'sd1000, 1'b1);
        send_sample(-16'sd5, 1'b1);
        configure(9'd511, 9'd257);
        send_sample(16'sd77, 1'b1);
        send_sample(16'sh8000, 1'b1);
        configure(9'd255, 9'd1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sd0, 1'b1);
        drain();
    endtask

    // No idling on either side; tiny blocks fill the queue and stall the sample side.
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (FULL_RATE_ITEMS) send_sample(pick_sample(), $urandom_range(2) == 0);
        send_sample(pick_sample(), 1'b1);
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_levels();
        int first;
        int next_cfg;
        first = samples_sent;
        next_cfg = CFG_SPACING;
        while (samples_sent - first < RANDOM_SAMPLES)
        begin
            send_random_block();
            if (samples_sent - first >= next_cfg)
            begin
                configure(pick_weight(), pick_weight());
                next_cfg += CFG_SPACING;
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_weights();
        test_block_max();
        test_weight_extremes();
        test_full_rate();
        test_random_levels();
        $display("Covered %0d samples and %0d block results under %0d weight settings",
                 samples_sent, blocks_checked, weight_settings + 1);
        $display("Field mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("Timeout with %0d results outstanding", level_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
